### hw/rtl/wsfd_pkg.sv
package wsfd_pkg;

   // Width kept for the declared payload length; extended length bits above it wrap away.
   localparam int LENGTH_BITS = 64;
   localparam int OUT_LEN_BITS = 64;

   localparam logic [3:0] OP_CONTINUATION = 4'h0;
   localparam logic [3:0] OP_TEXT         = 4'h1;
   localparam logic [3:0] OP_BINARY       = 4'h2;
   localparam logic [3:0] OP_CLOSE        = 4'h8;
   localparam logic [3:0] OP_PING         = 4'h9;
   localparam logic [3:0] OP_PONG         = 4'hA;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Extended length bytes still due, minus one.
   localparam logic [2:0] EXT16_COUNT = 3'd1;
   localparam logic [2:0] EXT64_COUNT = 3'd7;

   localparam logic [1:0] LAST_KEY_INDEX = 2'd3;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4,
      PH_HALT = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]              data_byte;
      logic                    has_data;
      logic [3:0]              frame_opcode;
      logic                    final_fragment;
      logic [OUT_LEN_BITS-1:0] payload_length;
      logic                    last_of_frame;
      logic                    bad_opcode;
      logic                    passthrough;
   } result_type;

   function automatic logic opcode_ok(input logic [3:0] op);
      return (op == OP_CONTINUATION) || (op == OP_TEXT) || (op == OP_BINARY) ||
             (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage

### hw/rtl/wsfd_ifs.sv
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        has_data;
   logic [3:0]  frame_opcode;
   logic        final_fragment;
   logic [63:0] payload_length;
   logic        last_of_frame;
   logic        bad_opcode;
   logic        passthrough;

   modport source (output valid, output data_byte, output has_data, output frame_opcode,
                   output final_fragment, output payload_length, output last_of_frame,
                   output bad_opcode, output passthrough, input ready);
   modport sink   (input valid, input data_byte, input has_data, input frame_opcode,
                   input final_fragment, input payload_length, input last_of_frame,
                   input bad_opcode, input passthrough, output ready);
endinterface

interface wsfd_csr_if;
   logic valid;
   logic ready;
   logic upgraded;

   modport source (output valid, output upgraded, input ready);
   modport sink   (input valid, input upgraded, output ready);
endinterface

### hw/rtl/websocket_frame_deframer_unit.sv
// WebSocket receive-side deframer, one stream byte per beat.
// req_chan carries stream bytes from the link; rsp_chan carries one result per payload
// byte, one marker per empty frame, one error per bad opcode, or one raw byte per beat
// while csr_chan has written upgraded as 0. Header and mask key bytes give no result.
// csr_chan is always ready and holds the upgraded bit; write it only while idle.
// Throughput is one byte per cycle while req_chan.ready is high: the header parser, the
// 64-bit remaining-count decrement and compare, and the key XOR all settle within the
// accepting cycle. An accepted byte's result is registered before it shows on rsp_chan.
// Results land in a two-entry output register (main plus skid), so a byte is still
// taken while a result waits; req_chan.ready falls only when both entries are full,
// and rises again the cycle after rsp_chan.ready takes one.
// Reset (synchronous) empties the output register, clears upgraded and puts the
// parser at the first header byte. After a bad opcode every byte is taken and
// dropped until reset.
module websocket_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   wsfd_req_if.sink   req_chan,
   wsfd_rsp_if.source rsp_chan,
   wsfd_csr_if.sink   csr_chan
);
   import wsfd_pkg::*;

   logic       upgraded_ff, upgraded_in;
   logic       beat;
   logic       space;
   logic       res_valid;
   result_type res;
   result_type out_data;

   assign csr_chan.ready = 1'b1;
   assign upgraded_in    = csr_chan.valid ? csr_chan.upgraded : upgraded_ff;

   always_ff @(posedge clock) begin
      if (reset) upgraded_ff <= 1'b0;
      else       upgraded_ff <= upgraded_in;
   end

   assign req_chan.ready = space;
   assign beat           = req_chan.valid && space;

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .upgraded  (upgraded_ff),
      .beat      (beat),
      .in_byte   (req_chan.stream_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.data_byte      = out_data.data_byte;
   assign rsp_chan.has_data       = out_data.has_data;
   assign rsp_chan.frame_opcode   = out_data.frame_opcode;
   assign rsp_chan.final_fragment = out_data.final_fragment;
   assign rsp_chan.payload_length = out_data.payload_length;
   assign rsp_chan.last_of_frame  = out_data.last_of_frame;
   assign rsp_chan.bad_opcode     = out_data.bad_opcode;
   assign rsp_chan.passthrough    = out_data.passthrough;

endmodule

### hw/rtl/wsfd_parser.sv
module wsfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                upgraded,
   input  logic                beat,
   input  logic [7:0]          in_byte,
   output logic                res_valid,
   output wsfd_pkg::result_type res
);
   import wsfd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [2:0]             ext_count_ff, ext_count_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             index_ff, index_in;
   logic                   masked_ff, masked_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             opcode_ff, opcode_in;

   logic                   active;
   logic [6:0]             len_code;
   logic                   code_ext;
   logic [LENGTH_BITS-1:0] len_code_ext;
   logic [LENGTH_BITS-1:0] len_shift;
   logic [1:0]             key_sel;
   logic [7:0]             key_byte;

   // A beat that the frame parser sees; passthrough and halted beats leave it alone.
   assign active       = beat && upgraded && (phase_ff != PH_HALT);
   assign len_code     = in_byte[6:0];
   assign code_ext     = (len_code == LEN_CODE_EXT16) || (len_code == LEN_CODE_EXT64);
   assign len_code_ext = LENGTH_BITS'(len_code);
   assign len_shift    = {length_ff[LENGTH_BITS-9:0], in_byte};
   assign key_sel      = LAST_KEY_INDEX - index_ff;
   assign key_byte     = masked_ff ? key_ff[{key_sel, 3'b000} +: 8] : 8'h00;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (phase_ff)
            PH_HDR0: phase_in = opcode_ok(in_byte[3:0]) ? PH_HDR1 : PH_HALT;
            PH_HDR1: begin
               if (code_ext)              phase_in = PH_EXT;
               else if (in_byte[7])       phase_in = PH_KEY;
               else if (len_code == 7'd0) phase_in = PH_HDR0;
               else                       phase_in = PH_DATA;
            end
            PH_EXT: begin
               if (ext_count_ff == 3'd0) begin
                  if (masked_ff)                           phase_in = PH_KEY;
                  else if (len_shift == '0)                phase_in = PH_HDR0;
                  else                                     phase_in = PH_DATA;
               end
            end
            PH_KEY: begin
               if (index_ff == LAST_KEY_INDEX)
                  phase_in = (length_ff == '0) ? PH_HDR0 : PH_DATA;
            end
            PH_DATA: begin
               if (remaining_ff == LENGTH_BITS'(1)) phase_in = PH_HDR0;
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_HALT;
         endcase
      end
   end

   // Result of the beat, if it causes one.
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (beat && (phase_ff != PH_HALT)) begin
         if (!upgraded) begin
            res_valid       = 1'b1;
            res.data_byte   = in_byte;
            res.has_data    = 1'b1;
            res.passthrough = 1'b1;
         end else begin
            res.frame_opcode   = opcode_ff;
            res.final_fragment = fin_ff;
            res.last_of_frame  = 1'b1;
            unique case (phase_ff)
               PH_HDR0: begin
                  res_valid          = !opcode_ok(in_byte[3:0]);
                  res.frame_opcode   = in_byte[3:0];
                  res.final_fragment = in_byte[7];
                  res.bad_opcode     = 1'b1;
               end
               PH_HDR1: res_valid = !code_ext && !in_byte[7] && (len_code == 7'd0);
               PH_EXT:  res_valid = (ext_count_ff == 3'd0) && !masked_ff && (len_shift == '0);
               PH_KEY:  res_valid = (index_ff == LAST_KEY_INDEX) && (length_ff == '0);
               PH_DATA: begin
                  res_valid          = 1'b1;
                  res.data_byte      = in_byte ^ key_byte;
                  res.has_data       = 1'b1;
                  res.payload_length = OUT_LEN_BITS'(length_ff);
                  res.last_of_frame  = (remaining_ff == LENGTH_BITS'(1));
               end
               default: res_valid = 1'b0;
            endcase
         end
      end
   end

   // Header fields, length, key and payload counters.
   always_comb begin
      ext_count_in = ext_count_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      index_in     = index_ff;
      masked_in    = masked_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      if (active) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = in_byte[7];
               opcode_in = in_byte[3:0];
            end
            PH_HDR1: begin
               masked_in = in_byte[7];
               if (len_code == LEN_CODE_EXT16) begin
                  length_in    = '0;
                  ext_count_in = EXT16_COUNT;
               end else if (len_code == LEN_CODE_EXT64) begin
                  length_in    = '0;
                  ext_count_in = EXT64_COUNT;
               end else begin
                  length_in    = len_code_ext;
                  index_in     = 2'd0;
                  remaining_in = len_code_ext;
                  if (in_byte[7]) key_in = '0;
               end
            end
            PH_EXT: begin
               length_in = len_shift;
               if (ext_count_ff == 3'd0) begin
                  index_in     = 2'd0;
                  remaining_in = len_shift;
                  if (masked_ff) key_in = '0;
               end else begin
                  ext_count_in = ext_count_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], in_byte};
               if (index_ff == LAST_KEY_INDEX) begin
                  index_in     = 2'd0;
                  remaining_in = length_ff;
               end else begin
                  index_in = index_ff + 2'd1;
               end
            end
            PH_DATA: begin
               index_in     = index_ff + 2'd1;
               remaining_in = remaining_ff - LENGTH_BITS'(1);
            end
            default: begin
               index_in = index_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_count_ff <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         key_ff       <= '0;
         index_ff     <= '0;
         masked_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         ext_count_ff <= ext_count_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         index_ff     <= index_in;
         masked_ff    <= masked_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
      end
   end

endmodule

### hw/rtl/wsfd_out_buf.sv
module wsfd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsfd_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   output wsfd_pkg::result_type out_data,
   input  logic                 out_ready
);
   import wsfd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   // Input side only stops once the skid entry is taken as well.
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### hw/rtl/wsfd_checker.sv
module wsfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_has_data,
   input logic        rsp_last_of_frame,
   input logic        rsp_bad_opcode,
   input logic        rsp_passthrough,
   input logic [63:0] rsp_payload_length
);

   // A stalled result beat must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // The error beat closes the frame and carries neither data nor length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_opcode |->
         rsp_last_of_frame && !rsp_has_data && (rsp_payload_length == 64'd0))
      else $error("malformed error beat");

   // A raw byte carries data and no frame flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_passthrough |-> rsp_has_data && !rsp_last_of_frame && !rsp_bad_opcode)
      else $error("malformed passthrough beat");

   // Once the error beat is taken the block stays silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_bad_opcode |=> !rsp_valid)
      else $error("result after the error beat");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_has_data       (rsp_chan.has_data),
   .rsp_last_of_frame  (rsp_chan.last_of_frame),
   .rsp_bad_opcode     (rsp_chan.bad_opcode),
   .rsp_passthrough    (rsp_chan.passthrough),
   .rsp_payload_length (rsp_chan.payload_length)
);
